### rtl/tty_input_line_discipline_defines.svh
// assertion macros used by the line discipline back end
`ifndef TTY_INPUT_LINE_DISCIPLINE_DEFINES_SVH
`define TTY_INPUT_LINE_DISCIPLINE_DEFINES_SVH

// holds at every edge out of reset
`define TILD_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define TILD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TILD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tild_pkg.sv
// shared types and constants of the tty input line discipline
`default_nettype none

package tild_pkg;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_NL    = 8'h0a;
    localparam logic [7:0] CHAR_CARET = 8'h5e;
    localparam logic [7:0] CTRL_BIAS  = 8'd64;

    localparam int LINE_W = 11;
    localparam logic [LINE_W-1:0] LINE_MAX = 11'd2047;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_DISCARD = 2'd2;

    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_INTR = 2'd1;
    localparam logic [1:0] SIG_QUIT = 2'd2;
    localparam logic [1:0] SIG_STOP = 2'd3;

    localparam logic [2:0] REG_INPUT_FLAGS = 3'd0;
    localparam logic [2:0] REG_LOCAL_FLAGS = 3'd1;
    localparam logic [2:0] REG_INTR_CHAR   = 3'd2;
    localparam logic [2:0] REG_QUIT_CHAR   = 3'd3;
    localparam logic [2:0] REG_SUSP_CHAR   = 3'd4;

    typedef struct packed {
        logic [4:0] input_flags;
        logic [3:0] local_flags;
        logic [7:0] interrupt_char;
        logic [7:0] quit_char;
        logic [7:0] suspend_char;
    } tild_cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        logic       nl;
        logic [1:0] echo_count;
        logic [7:0] echo_first;
        logic [7:0] echo_second;
        logic [1:0] signal_code;
    } tild_op_t;

endpackage

`default_nettype wire

### rtl/tty_input_line_discipline.sv
// Terminal input line discipline. One item is accepted per clock and one result leaves per
// clock when the output side keeps up; an item taken passes through the two-entry queue
// behind the byte mapper and then the result register that the cooked store's registered
// read port feeds. The store has no clearing pass after reset, since only entries covered
// by the fill count are ever read. Configuration must be written through the APB port only
// while the block is idle; the block itself does not enforce this.
`default_nettype none

module tty_input_line_discipline
    import tild_pkg::*;
#(
    parameter int FIFO_DEPTH = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [7:0]  raw_char,
    input  wire logic        echo_room,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       echo_count,
    output logic [7:0]       echo_first,
    output logic [7:0]       echo_second,
    output logic [1:0]       signal_code,
    output logic             stored,
    output logic             dropped,
    output logic             read_valid,
    output logic [7:0]       read_char,
    output logic             line_end,
    output logic             input_available
);

    tild_cfg_t cfg;
    tild_op_t  front_op;
    tild_op_t  head_op;
    logic      q_not_full;
    logic      q_not_empty;
    logic      q_pop;

    assign in_ready = q_not_full;

    tild_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tild_front u_front (
        .func      (func),
        .raw_char  (raw_char),
        .echo_room (echo_room),
        .cfg       (cfg),
        .op        (front_op)
    );

    tild_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && q_not_full),
        .push_data (front_op),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (head_op)
    );

    tild_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .canon           (cfg.local_flags[1]),
        .op_valid        (q_not_empty),
        .op              (head_op),
        .op_take         (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .echo_count      (echo_count),
        .echo_first      (echo_first),
        .echo_second     (echo_second),
        .signal_code     (signal_code),
        .stored          (stored),
        .dropped         (dropped),
        .read_valid      (read_valid),
        .read_char       (read_char),
        .line_end        (line_end),
        .input_available (input_available)
    );

endmodule

`default_nettype wire

### rtl/tild_cfg.sv
// apb configuration registers
`default_nettype none

module tild_cfg
    import tild_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output tild_cfg_t        cfg
);

    tild_cfg_t cfg_reg;
    tild_cfg_t cfg_next;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_INPUT_FLAGS: cfg_next.input_flags    = pwdata[4:0];
                REG_LOCAL_FLAGS: cfg_next.local_flags    = pwdata[3:0];
                REG_INTR_CHAR:   cfg_next.interrupt_char = pwdata[7:0];
                REG_QUIT_CHAR:   cfg_next.quit_char      = pwdata[7:0];
                REG_SUSP_CHAR:   cfg_next.suspend_char   = pwdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_INPUT_FLAGS: prdata = {27'd0, cfg_reg.input_flags};
            REG_LOCAL_FLAGS: prdata = {28'd0, cfg_reg.local_flags};
            REG_INTR_CHAR:   prdata = {24'd0, cfg_reg.interrupt_char};
            REG_QUIT_CHAR:   prdata = {24'd0, cfg_reg.quit_char};
            REG_SUSP_CHAR:   prdata = {24'd0, cfg_reg.suspend_char};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_flags    <= 5'd4;
            cfg_reg.local_flags    <= 4'd15;
            cfg_reg.interrupt_char <= 8'd3;
            cfg_reg.quit_char      <= 8'd28;
            cfg_reg.suspend_char   <= 8'd26;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tild_front.sv
// front end: byte mapping, signal detection and echo forming
`default_nettype none

module tild_front
    import tild_pkg::*;
(
    input  wire logic       func,
    input  wire logic [7:0] raw_char,
    input  wire logic       echo_room,
    input  wire tild_cfg_t  cfg,
    output tild_op_t        op
);

    logic [7:0] c_strip;
    logic [7:0] c_low;
    logic [7:0] c_map;
    logic       cr_drop;
    logic [1:0] sig;
    logic       is_ctrl;
    logic       is_space;

    always_comb
    begin
        c_strip = cfg.input_flags[0] ? {1'b0, raw_char[6:0]} : raw_char;
        c_low = c_strip;
        if (cfg.input_flags[1] && c_strip >= 8'h41 && c_strip <= 8'h5a)
        begin
            c_low = c_strip + 8'd32;
        end

        cr_drop = 1'b0;
        c_map   = c_low;
        if (c_low == CHAR_CR)
        begin
            cr_drop = cfg.input_flags[3];
            if (cfg.input_flags[2])
            begin
                c_map = CHAR_NL;
            end
        end
        else if (c_low == CHAR_NL && cfg.input_flags[4])
        begin
            c_map = CHAR_CR;
        end

        sig = SIG_NONE;
        if (cfg.local_flags[0])
        begin
            if (c_map == cfg.interrupt_char)
            begin
                sig = SIG_INTR;
            end
            else if (c_map == cfg.quit_char)
            begin
                sig = SIG_QUIT;
            end
            else if (c_map == cfg.suspend_char)
            begin
                sig = SIG_STOP;
            end
        end

        is_ctrl  = (c_map < 8'd32) || (c_map == 8'd127);
        is_space = (c_map >= 8'd9 && c_map <= 8'd13) || (c_map == 8'd32);

        op = '0;
        if (func)
        begin
            op.op = OP_READ;
        end
        else if (cr_drop)
        begin
            op.op = OP_DISCARD;
        end
        else if (sig != SIG_NONE)
        begin
            op.op          = OP_DISCARD;
            op.signal_code = sig;
        end
        else
        begin
            op.op = OP_WRITE;
            op.ch = c_map;
            op.nl = cfg.local_flags[1] && (c_map == CHAR_NL);
            if (cfg.local_flags[2] && echo_room)
            begin
                if (is_ctrl && !is_space && cfg.local_flags[3])
                begin
                    op.echo_count  = 2'd2;
                    op.echo_first  = CHAR_CARET;
                    op.echo_second = c_map + CTRL_BIAS;
                end
                else
                begin
                    op.echo_count = 2'd1;
                    op.echo_first = c_map;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/tild_queue.sv
// two-entry queue between front and back
`default_nettype none

module tild_queue
    import tild_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire tild_op_t push_data,
    output logic          not_full,
    input  wire logic     pop,
    output logic          not_empty,
    output tild_op_t      head_data
);

    tild_op_t   entry_reg [2];
    logic       head_reg;
    logic       head_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       tail;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_data = entry_reg[head_reg];
    assign tail      = head_reg ^ count_reg[0];

    always_comb
    begin
        head_next  = pop ? ~head_reg : head_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tild_back.sv
// back end: cooked byte store, fill and line accounting, result register
`default_nettype none

`include "tty_input_line_discipline_defines.svh"

module tild_back
    import tild_pkg::*;
#(
    parameter int FIFO_DEPTH = 1024
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       canon,
    input  wire logic       op_valid,
    input  wire tild_op_t   op,
    output logic            op_take,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      echo_count,
    output logic [7:0]      echo_first,
    output logic [7:0]      echo_second,
    output logic [1:0]      signal_code,
    output logic            stored,
    output logic            dropped,
    output logic            read_valid,
    output logic [7:0]      read_char,
    output logic            line_end,
    output logic            input_available
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    typedef struct packed {
        logic [1:0] echo_count;
        logic [7:0] echo_first;
        logic [7:0] echo_second;
        logic [1:0] signal_code;
        logic       stored;
        logic       dropped;
        logic       read_valid;
        logic       nl_stored;
        logic       fill_nz;
    } tild_res_t;

    logic [7:0]        store_mem [FIFO_DEPTH];
    logic [7:0]        rd_data_reg;

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              res_valid_reg, res_valid_next;
    tild_res_t         res_reg, res_next;

    logic              do_write;
    logic              do_read;
    logic              out_take;

    assign out_take = out_valid && out_ready;
    assign op_take  = op_valid && (!res_valid_reg || out_ready);
    assign do_write = op_take && (op.op == OP_WRITE) && (fill_reg != CNT_FULL);
    assign do_read  = op_take && (op.op == OP_READ) && (fill_reg != '0);

    always_comb
    begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        fill_next = fill_reg;
        if (do_write)
        begin
            wp_next   = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        if (do_read)
        begin
            rp_next   = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end

        res_next             = res_reg;
        res_valid_next       = res_valid_reg && !out_take;
        if (op_take)
        begin
            res_valid_next       = 1'b1;
            res_next.echo_count  = op.echo_count;
            res_next.echo_first  = op.echo_first;
            res_next.echo_second = op.echo_second;
            res_next.signal_code = op.signal_code;
            res_next.stored      = do_write;
            res_next.dropped     = (op.op == OP_WRITE) && !do_write;
            res_next.read_valid  = do_read;
            res_next.nl_stored   = do_write && op.nl;
            res_next.fill_nz     = (fill_next != '0);
        end
    end

    // line accounting runs in result order, once the popped byte is known
    always_comb
    begin
        line_next = line_reg;
        if (res_reg.nl_stored && line_reg != LINE_MAX)
        begin
            line_next = line_reg + 1'b1;
        end
        else if (line_end && line_reg != '0)
        begin
            line_next = line_reg - 1'b1;
        end
    end

    assign out_valid       = res_valid_reg;
    assign echo_count      = res_reg.echo_count;
    assign echo_first      = res_reg.echo_first;
    assign echo_second     = res_reg.echo_second;
    assign signal_code     = res_reg.signal_code;
    assign stored          = res_reg.stored;
    assign dropped         = res_reg.dropped;
    assign read_valid      = res_reg.read_valid;
    assign read_char       = res_reg.read_valid ? rd_data_reg : 8'd0;
    assign line_end        = res_reg.read_valid && canon && (rd_data_reg == CHAR_NL);
    assign input_available = canon ? (line_next != '0) : res_reg.fill_nz;

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            store_mem[wp_reg] <= op.ch;
        end
        if (do_read)
        begin
            rd_data_reg <= store_mem[rp_reg];
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            fill_reg      <= '0;
            line_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
            if (out_take)
            begin
                line_reg <= line_next;
            end
        end
    end

    `TILD_ASSERT_NOW(a_fill_bound, fill_reg <= CNT_FULL, "fill count above depth")
    `TILD_ASSERT_NEXT(a_fill_inc, do_write, fill_reg == $past(fill_reg) + 1'b1, "fill not raised")
    `TILD_ASSERT_IMPL(a_res_excl, out_valid && read_valid, !stored && !dropped,
        "read result carries write flags")
    `TILD_ASSERT_IMPL(a_ptr_wrap, fill_reg == '0, wp_reg == rp_reg, "empty store with pointer gap")

endmodule

`default_nettype wire

### tb/tild_tb_pkg.sv
// predictor and scoreboard for the tty input line discipline testbench
package tild_tb_pkg;
    import tild_pkg::*;

    localparam logic FUNC_RECV = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam int COOKED_DEPTH = 1024;

    localparam logic [4:0] IF_STRIP = 5'h01;
    localparam logic [4:0] IF_LCASE = 5'h02;
    localparam logic [4:0] IF_ICRNL = 5'h04;
    localparam logic [4:0] IF_IGNCR = 5'h08;
    localparam logic [4:0] IF_INLCR = 5'h10;

    localparam logic [3:0] LF_SIG     = 4'h1;
    localparam logic [3:0] LF_CANON   = 4'h2;
    localparam logic [3:0] LF_ECHO    = 4'h4;
    localparam logic [3:0] LF_ECHOCTL = 4'h8;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7f;

    localparam logic [7:0] DEF_INTR_CHAR = 8'd3;
    localparam logic [7:0] DEF_QUIT_CHAR = 8'd28;
    localparam logic [7:0] DEF_SUSP_CHAR = 8'd26;

    typedef struct packed {
        logic [1:0] echo_count;
        logic [7:0] echo_first;
        logic [7:0] echo_second;
        logic [1:0] signal_code;
        logic       stored;
        logic       dropped;
        logic       read_valid;
        logic [7:0] read_char;
        logic       line_end;
        logic       input_available;
    } line_result_t;

    class tild_scoreboard;
        logic [4:0] in_flags;
        logic [3:0] loc_flags;
        logic [7:0] intr_ch;
        logic [7:0] quit_ch;
        logic [7:0] susp_ch;

        logic [7:0]  cooked [COOKED_DEPTH];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        int unsigned fill;
        int unsigned lines;

        line_result_t pending [$];
        int unsigned  errors;

        function new();
            in_flags  = IF_ICRNL;
            loc_flags = LF_SIG | LF_CANON | LF_ECHO | LF_ECHOCTL;
            intr_ch   = DEF_INTR_CHAR;
            quit_ch   = DEF_QUIT_CHAR;
            susp_ch   = DEF_SUSP_CHAR;
            wr_ptr    = 0;
            rd_ptr    = 0;
            fill      = 0;
            lines     = 0;
            errors    = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_INPUT_FLAGS: in_flags  = value[4:0];
                REG_LOCAL_FLAGS: loc_flags = value[3:0];
                REG_INTR_CHAR:   intr_ch   = value[7:0];
                REG_QUIT_CHAR:   quit_ch   = value[7:0];
                REG_SUSP_CHAR:   susp_ch   = value[7:0];
                default: ;
            endcase
        endfunction

        // works out the result of one accepted input beat
        function void note_beat(logic fn, logic [7:0] ch, logic room);
            line_result_t r;
            logic [7:0]   c;
            logic [1:0]   sig;
            logic         done;
            logic         is_ctrl;
            logic         is_space;
            r    = '0;
            c    = ch;
            done = 1'b0;
            if (fn == FUNC_READ) begin
                if (fill > 0) begin
                    r.read_valid = 1'b1;
                    r.read_char  = cooked[rd_ptr];
                    rd_ptr       = (rd_ptr + 1) % COOKED_DEPTH;
                    fill--;
                    if ((loc_flags & LF_CANON) != 0 && r.read_char == CHAR_NL) begin
                        r.line_end = 1'b1;
                        if (lines > 0)
                            lines--;
                    end
                end
            end
            else begin
                if ((in_flags & IF_STRIP) != 0)
                    c[7] = 1'b0;
                if ((in_flags & IF_LCASE) != 0 && c >= "A" && c <= "Z")
                    c = c + 8'd32;
                if (c == CHAR_CR) begin
                    if ((in_flags & IF_IGNCR) != 0)
                        done = 1'b1;
                    else if ((in_flags & IF_ICRNL) != 0)
                        c = CHAR_NL;
                end
                else if (c == CHAR_NL && (in_flags & IF_INLCR) != 0) begin
                    c = CHAR_CR;
                end
                if (!done && (loc_flags & LF_SIG) != 0) begin
                    if (c == intr_ch)
                        sig = SIG_INTR;
                    else if (c == quit_ch)
                        sig = SIG_QUIT;
                    else if (c == susp_ch)
                        sig = SIG_STOP;
                    else
                        sig = SIG_NONE;
                    if (sig != SIG_NONE) begin
                        r.signal_code = sig;
                        done          = 1'b1;
                    end
                end
                if (!done) begin
                    is_ctrl  = (c < CHAR_SPACE) || (c == CHAR_DEL);
                    is_space = (c >= CHAR_TAB && c <= CHAR_CR) || (c == CHAR_SPACE);
                    if ((loc_flags & LF_ECHO) != 0 && room) begin
                        if (is_ctrl && !is_space && (loc_flags & LF_ECHOCTL) != 0) begin
                            r.echo_count  = 2'd2;
                            r.echo_first  = CHAR_CARET;
                            r.echo_second = c + CTRL_BIAS;
                        end
                        else begin
                            r.echo_count = 2'd1;
                            r.echo_first = c;
                        end
                    end
                    if (fill < COOKED_DEPTH) begin
                        cooked[wr_ptr] = c;
                        wr_ptr         = (wr_ptr + 1) % COOKED_DEPTH;
                        fill++;
                        r.stored = 1'b1;
                        if ((loc_flags & LF_CANON) != 0 && c == CHAR_NL && lines < LINE_MAX)
                            lines++;
                    end
                    else begin
                        r.dropped = 1'b1;
                    end
                end
            end
            r.input_available = ((loc_flags & LF_CANON) != 0) ? (lines > 0) : (fill > 0);
            pending.push_back(r);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_beat(line_result_t got);
            line_result_t want;
            if (pending.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
                return;
            end
            want = pending.pop_front();
            check_field("echo_count", 8'(want.echo_count), 8'(got.echo_count));
            check_field("echo_first", want.echo_first, got.echo_first);
            check_field("echo_second", want.echo_second, got.echo_second);
            check_field("signal_code", 8'(want.signal_code), 8'(got.signal_code));
            check_field("stored", 8'(want.stored), 8'(got.stored));
            check_field("dropped", 8'(want.dropped), 8'(got.dropped));
            check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
            check_field("read_char", want.read_char, got.read_char);
            check_field("line_end", 8'(want.line_end), 8'(got.line_end));
            check_field("input_available", 8'(want.input_available),
                        8'(got.input_available));
        endfunction
    endclass

endpackage

### tb/tb.sv
// top level testbench for the tty input line discipline
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tild_pkg::*;
    import tild_tb_pkg::*;

    localparam int FLOOD_BEATS = COOKED_DEPTH + 6;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [4:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        func      = 1'b0;
    logic [7:0]  raw_char  = '0;
    logic        echo_room = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  echo_count;
    logic [7:0]  echo_first;
    logic [7:0]  echo_second;
    logic [1:0]  signal_code;
    logic        stored;
    logic        dropped;
    logic        read_valid;
    logic [7:0]  read_char;
    logic        line_end;
    logic        input_available;

    int unsigned send_idle_pct = 36;
    int unsigned recv_idle_pct = 86;

    tild_scoreboard sb = new();

    tty_input_line_discipline dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .raw_char        (raw_char),
        .echo_room       (echo_room),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .echo_count      (echo_count),
        .echo_first      (echo_first),
        .echo_second     (echo_second),
        .signal_code     (signal_code),
        .stored          (stored),
        .dropped         (dropped),
        .read_valid      (read_valid),
        .read_char       (read_char),
        .line_end        (line_end),
        .input_available (input_available)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat('{echo_count, echo_first, echo_second, signal_code, stored,
                            dropped, read_valid, read_char, line_end, input_available});
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic write_config(input logic [4:0] iflags, input logic [3:0] lflags,
                                input logic [7:0] intr_c, input logic [7:0] quit_c,
                                input logic [7:0] susp_c);
        write_reg(REG_INPUT_FLAGS, {27'd0, iflags});
        write_reg(REG_LOCAL_FLAGS, {28'd0, lflags});
        write_reg(REG_INTR_CHAR, {24'd0, intr_c});
        write_reg(REG_QUIT_CHAR, {24'd0, quit_c});
        write_reg(REG_SUSP_CHAR, {24'd0, susp_c});
    endtask

    task automatic send_beat(input logic fn, input logic [7:0] ch, input logic room);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= fn;
        raw_char  <= ch;
        echo_room <= room;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_beat(fn, ch, room);
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_signal_char();
        case ($urandom_range(0, 7))
            0: return DEF_INTR_CHAR;
            1: return DEF_QUIT_CHAR;
            2: return DEF_SUSP_CHAR;
            3: return "q";
            4: return CHAR_CR;
            5: return CHAR_NL;
            6: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] any_char();
        case ($urandom_range(0, 9))
            0, 1: return 8'($urandom_range(0, 255));
            2: return sb.intr_ch;
            3: return ($urandom_range(0, 1) != 0) ? sb.quit_ch : sb.susp_ch;
            4: return CHAR_CR;
            5: return CHAR_NL;
            6: return 8'($urandom_range(0, 31));
            7: return CHAR_DEL;
            8: return {1'($urandom_range(0, 1)), 7'($urandom_range(65, 90))};
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    task automatic random_config();
        write_config(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                     pick_signal_char(), pick_signal_char(), pick_signal_char());
    endtask

    // mostly whole lines of text read back, with read bursts and noise in between
    task automatic random_segment(input int n_beats);
        int sent;
        int len;
        int kind;
        sent = 0;
        while (sent < n_beats) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                len = $urandom_range(0, 12);
                repeat (len)
                    send_beat(FUNC_RECV, 8'($urandom_range(32, 126)), 1'($urandom_range(0, 1)));
                send_beat(FUNC_RECV, ($urandom_range(0, 1) != 0) ? CHAR_CR : CHAR_NL,
                          1'($urandom_range(0, 1)));
                sent += len + 1;
                if (kind <= 4) begin
                    len = len + 1 + $urandom_range(0, 4) - 2;
                    repeat (len)
                        send_beat(FUNC_READ, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                    sent += len;
                end
            end
            else if (kind == 7 || kind == 8) begin
                len = $urandom_range(1, 16);
                repeat (len)
                    send_beat(FUNC_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent += len;
            end
            else begin
                len = $urandom_range(1, 8);
                repeat (len)
                    send_beat(1'($urandom_range(0, 1)), any_char(), 1'($urandom_range(0, 1)));
                sent += len;
            end
        end
    endtask

    // fill to overflow in canonical mode, then read part of it back
    task automatic flood_lines();
        write_reg(REG_INPUT_FLAGS, {27'd0, IF_ICRNL | 5'($urandom_range(0, 3))});
        write_reg(REG_LOCAL_FLAGS, {28'd0, LF_CANON | LF_ECHO | LF_ECHOCTL});
        repeat (FLOOD_BEATS)
            send_beat(FUNC_RECV, ($urandom_range(0, 1) != 0) ? CHAR_CR : CHAR_NL,
                      1'($urandom_range(0, 1)));
        wait_results_done();
        repeat (40)
            send_beat(FUNC_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic directed_beats();
        // reset configuration: cr to nl, signals, canonical, caret echo
        send_beat(FUNC_READ, 8'h00, 1'b1);
        send_beat(FUNC_RECV, "a", 1'b1);
        send_beat(FUNC_RECV, 8'h00, 1'b1);
        send_beat(FUNC_RECV, DEF_INTR_CHAR, 1'b1);
        send_beat(FUNC_RECV, DEF_QUIT_CHAR, 1'b1);
        send_beat(FUNC_RECV, DEF_SUSP_CHAR, 1'b1);
        send_beat(FUNC_RECV, CHAR_TAB, 1'b1);
        send_beat(FUNC_RECV, CHAR_DEL, 1'b1);
        send_beat(FUNC_RECV, 8'hff, 1'b1);
        send_beat(FUNC_RECV, CHAR_CR, 1'b1);
        send_beat(FUNC_RECV, "b", 1'b0);
        repeat (7)
            send_beat(FUNC_READ, 8'hff, 1'b0);
        wait_results_done();

        // all input flags, no canonical mode, raw control echo, shared signal chars
        write_config(5'h1f, LF_SIG | LF_ECHO, "q", "q", 8'hff);
        send_beat(FUNC_RECV, "Q", 1'b1);
        send_beat(FUNC_RECV, CHAR_CR, 1'b1);
        send_beat(FUNC_RECV, CHAR_NL, 1'b1);
        send_beat(FUNC_RECV, 8'hda, 1'b1);
        send_beat(FUNC_RECV, 8'h01, 1'b1);
        repeat (3)
            send_beat(FUNC_READ, 8'h00, 1'b1);
        wait_results_done();

        // newline stored outside canonical mode, read in it: count stays at zero
        write_config(5'h00, 4'h0, 8'h00, 8'h00, 8'h00);
        send_beat(FUNC_RECV, CHAR_NL, 1'b1);
        wait_results_done();
        write_reg(REG_LOCAL_FLAGS, {28'd0, LF_CANON});
        send_beat(FUNC_READ, 8'h00, 1'b0);
        wait_results_done();
    endtask

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_beats();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 86 : 0;
            recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 36 : 0;
            for (int seg = 0; seg < 6; seg++) begin
                if (seg == 0 && phase == 0)
                    write_config(5'h00, 4'h0, 8'h00, 8'h00, 8'h00);
                else if (seg == 0 && phase == 1)
                    write_config(5'h1f, 4'hf, 8'hff, 8'hff, 8'hff);
                else
                    random_config();
                random_segment(25);
                wait_results_done();
            end
        end

        flood_lines();
        wait_results_done();
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
